// ===== design/random_pick_without_repeat_defines.svh =====
// Assertion macros for the random pick block.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef RANDOM_PICK_WITHOUT_REPEAT_DEFINES_SVH
`define RANDOM_PICK_WITHOUT_REPEAT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define RPWR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rpwr assertion failed");

`define RPWR_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rpwr assertion failed");

`else

`define RPWR_ASSERT_IMP(name, ante, cons)

`define RPWR_ASSERT_NXT(name, ante, cons)

`endif

`endif

// ===== design/rpwr_pkg.sv =====
package rpwr_pkg;

  // Number of selectable slots and the widths that follow from it.
  localparam int SLOTS = 32;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CFG_W = CNT_W;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_PICK_RANGE = 1'b0,
    REG_NO_REPEAT  = 1'b1
  } cfg_reg_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the draw of an accepted item
    logic prep;  // range check, cycle restart, repeat-mode result
    logic scan;  // examine one slot of the used mask
  } rpwr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip;      // result is settled in the prep step, no scan needed
    logic scan_end;  // the current scan step finishes the item
  } rpwr_stat_t;

endpackage

// ===== design/rpwr_ctrl.sv =====
module rpwr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  output logic                 done_o,
  output rpwr_pkg::rpwr_cmd_t  cmd_o,
  input  rpwr_pkg::rpwr_stat_t stat_i
);
  import rpwr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_PREP;
      end
      ST_PREP: begin
        state_d = stat_i.skip ? ST_EMIT : ST_SCAN;
      end
      ST_SCAN: begin
        if (stat_i.scan_end) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy       = (state_q != ST_IDLE);
  assign done_o     = (state_q == ST_EMIT);
  assign cmd_o.load = (state_q == ST_IDLE) && start;
  assign cmd_o.prep = (state_q == ST_PREP);
  assign cmd_o.scan = (state_q == ST_SCAN);

endmodule

// ===== design/rpwr_datapath.sv =====
module rpwr_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [rpwr_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic [rpwr_pkg::IDX_W-1:0] draw_i,
  input  rpwr_pkg::rpwr_cmd_t        cmd_i,
  output rpwr_pkg::rpwr_stat_t       stat_o,
  output logic [rpwr_pkg::IDX_W-1:0] chosen_index_o,
  output logic                       status_o
);
  import rpwr_pkg::*;

  logic [CNT_W-1:0] range_q;
  logic             nrm_q;
  logic [SLOTS-1:0] mask_q, mask_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] draw_q;
  logic [IDX_W-1:0] want_q, want_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic [IDX_W-1:0] seen_q, seen_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             err_q, err_d;

  logic             clr;
  logic [CNT_W-1:0] eff_cnt;
  logic [CNT_W-1:0] free_cnt;
  logic [CNT_W-1:0] draw_ext;
  logic             zero_rng;
  logic             rep_oor;
  logic             nr_oor;
  logic             slot_free;
  logic             hit;
  logic             last;

  // Prep step: a full count restarts the cycle before the draw is checked.
  assign draw_ext  = CNT_W'(draw_q);
  assign zero_rng  = (range_q == '0);
  assign clr       = (count_q >= range_q);
  assign eff_cnt   = clr ? '0 : count_q;
  assign free_cnt  = range_q - eff_cnt;
  assign rep_oor   = !zero_rng && (draw_ext >= range_q);
  assign nr_oor    = !zero_rng && (draw_ext >= free_cnt);

  // Scan step: one slot per cycle, lowest slot first.
  assign slot_free = !mask_q[pos_q];
  assign hit       = slot_free && (seen_q == want_q);
  assign last      = (pos_q == IDX_W'(SLOTS - 1));

  assign stat_o.skip     = !nrm_q || nr_oor;
  assign stat_o.scan_end = hit || last;

  always_comb begin
    mask_d  = mask_q;
    count_d = count_q;
    want_d  = want_q;
    pos_d   = pos_q;
    seen_d  = seen_q;
    idx_d   = idx_q;
    err_d   = err_q;
    if (cmd_i.prep) begin
      if (!nrm_q) begin
        idx_d = (zero_rng || rep_oor) ? '0 : draw_q;
        err_d = rep_oor;
      end else begin
        if (clr) begin
          mask_d  = '0;
          count_d = '0;
        end
        want_d = zero_rng ? '0 : draw_q;
        pos_d  = '0;
        seen_d = '0;
        if (nr_oor) begin
          count_d = CNT_W'(SLOTS);
          idx_d   = '0;
          err_d   = 1'b1;
        end
      end
    end else if (cmd_i.scan) begin
      if (hit) begin
        mask_d[pos_q] = 1'b1;
        count_d       = count_q + CNT_W'(1);
        idx_d         = pos_q;
        err_d         = 1'b0;
      end else begin
        if (slot_free) seen_d = seen_q + IDX_W'(1);
        pos_d = pos_q + IDX_W'(1);
        if (last) begin
          count_d = CNT_W'(SLOTS);
          idx_d   = '0;
          err_d   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= '0;
      nrm_q   <= 1'b0;
      mask_q  <= '0;
      count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_PICK_RANGE: begin
            range_q <= (cfg_wdata_i > CFG_W'(SLOTS)) ? CNT_W'(SLOTS) : cfg_wdata_i;
          end
          REG_NO_REPEAT: begin
            nrm_q <= cfg_wdata_i[0];
          end
          default: begin
            nrm_q <= nrm_q;
          end
        endcase
      end
      mask_q  <= mask_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) draw_q <= draw_i;
    want_q <= want_d;
    pos_q  <= pos_d;
    seen_q <= seen_d;
    idx_q  <= idx_d;
    err_q  <= err_d;
  end

  assign chosen_index_o = idx_q;
  assign status_o       = err_q;

endmodule

// ===== design/random_pick_without_repeat.sv =====
// Channel   Ports                                   Handshake
// --------  --------------------------------------  ---------------------------------
// input     draw_i                                  taken when start && !busy
// result    chosen_index_o, status_o                shown for one cycle with done_o
// config    cfg_idx_i, cfg_wdata_i                  written when cfg_we_i is high
//
// An item goes from its prep step straight to its result cycle in repeat mode or when
// the draw is out of range; in no-repeat mode a slot scan comes between the two, where
// one slot of the used mask is examined per cycle. busy stays high through the cycle in
// which done_o is shown, so the next item is accepted in the cycle after it. Reset is
// asynchronous and active low; it clears the controller, the used mask, the used count
// and both configuration registers. There is no output stall: the receiver must take
// each result in the cycle that done_o marks.
`include "random_pick_without_repeat_defines.svh"

module random_pick_without_repeat (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [rpwr_pkg::IDX_W-1:0] draw_i,
  output logic                       done_o,
  output logic [rpwr_pkg::IDX_W-1:0] chosen_index_o,
  output logic                       status_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [rpwr_pkg::CFG_W-1:0] cfg_wdata_i
);
  import rpwr_pkg::*;

  // Commands and status between the sequencer and the datapath.
  rpwr_cmd_t  cmd;
  rpwr_stat_t stat;

  // The controller walks each item through a prep step, an optional slot
  // scan and a single result cycle.
  rpwr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  // The datapath holds the configuration, the used mask and count, the scan
  // counters and the result registers that drive the output ports.
  rpwr_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .draw_i         (draw_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .chosen_index_o (chosen_index_o),
    .status_o       (status_o)
  );

  // An accepted item always keeps the block busy in the next cycle.
  `RPWR_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  // A result is shown while the item is still in flight, never while idle.
  `RPWR_ASSERT_IMP(a_done_in_flight, done_o, busy)
  // Each item produces exactly one result cycle.
  `RPWR_ASSERT_NXT(a_done_single, done_o, !done_o)
  // An error result always carries index zero.
  `RPWR_ASSERT_IMP(a_err_index_zero, done_o && status_o, chosen_index_o == '0)

endmodule
